@@ rtl/core/cnt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnt_pkg
// shared types and widths for the cofactor normal transform pipeline
// ----------------------------------------------------------------------------
package cnt_pkg;

  localparam int IN_W         = 16;
  localparam int PROD_W       = 32;
  localparam int ADJ_W        = 33;
  localparam int VP_W         = 49;
  localparam int V_W          = 50;
  localparam int SH_W         = 6;
  localparam int MANT_W       = 16;
  localparam int SQ_W         = 2 * MANT_W;
  localparam int SUM_W        = SQ_W + 2;
  localparam int RHS_SHIFT    = 30;
  localparam int RHS_W        = SQ_W + RHS_SHIFT;
  localparam int ACC_W        = 68;
  localparam int Q_W          = 15;
  localparam int SEARCH_STEPS = 15;
  localparam int OUT_W        = 16;

  typedef struct packed {
    logic signed [IN_W-1:0] j00;
    logic signed [IN_W-1:0] j01;
    logic signed [IN_W-1:0] j02;
    logic signed [IN_W-1:0] j10;
    logic signed [IN_W-1:0] j11;
    logic signed [IN_W-1:0] j12;
    logic signed [IN_W-1:0] j20;
    logic signed [IN_W-1:0] j21;
    logic signed [IN_W-1:0] j22;
    logic signed [IN_W-1:0] n_x;
    logic signed [IN_W-1:0] n_y;
    logic signed [IN_W-1:0] n_z;
  } cnt_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic                    zero_length;
  } cnt_rsp_t;

  typedef struct packed {
    logic                      valid;
    logic [2:0][V_W-1:0]       v;
  } cnt_vec_t;

  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [2:0]                neg;
    logic [2:0][RHS_W-1:0]     rhs;
    logic [SUM_W-1:0]          s;
  } cnt_scl_t;

  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [2:0]                neg;
    logic [2:0][Q_W-1:0]       q;
  } cnt_mag_t;

endpackage

@@ rtl/core/cnt_adjugate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnt_adjugate
// four stages: minor products, adjugate, weighted products, sum to v
// ----------------------------------------------------------------------------
module cnt_adjugate import cnt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  cnt_req_t req_i,
  output cnt_vec_t vec_o
);

  logic signed [IN_W-1:0]   j [9];
  logic signed [IN_W-1:0]   n [3];
  logic signed [PROD_W-1:0] p_d [18];
  logic signed [PROD_W-1:0] p_q [18];
  logic signed [ADJ_W-1:0]  adj_q [9];
  logic signed [VP_W-1:0]   vp_d [9];
  logic signed [VP_W-1:0]   vp_q [9];
  logic signed [V_W-1:0]    v_q [3];
  logic                     valid1_q, valid2_q, valid3_q, valid4_q;
  // normal rides along to meet the adjugate
  logic signed [IN_W-1:0]   n1_q [3], n2_q [3];

  always_comb begin
    j[0] = req_i.j00; j[1] = req_i.j01; j[2] = req_i.j02;
    j[3] = req_i.j10; j[4] = req_i.j11; j[5] = req_i.j12;
    j[6] = req_i.j20; j[7] = req_i.j21; j[8] = req_i.j22;
    n[0] = req_i.n_x; n[1] = req_i.n_y; n[2] = req_i.n_z;
    // adjugate entry k is p[2k] - p[2k+1], row-major
    p_d[0]  = j[4] * j[8]; p_d[1]  = j[5] * j[7];
    p_d[2]  = j[2] * j[7]; p_d[3]  = j[1] * j[8];
    p_d[4]  = j[1] * j[5]; p_d[5]  = j[2] * j[4];
    p_d[6]  = j[5] * j[6]; p_d[7]  = j[3] * j[8];
    p_d[8]  = j[0] * j[8]; p_d[9]  = j[2] * j[6];
    p_d[10] = j[2] * j[3]; p_d[11] = j[0] * j[5];
    p_d[12] = j[3] * j[7]; p_d[13] = j[4] * j[6];
    p_d[14] = j[1] * j[6]; p_d[15] = j[0] * j[7];
    p_d[16] = j[0] * j[4]; p_d[17] = j[1] * j[3];
    for (int k = 0; k < 9; k++) begin
      vp_d[k] = adj_q[k] * n2_q[k / 3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    n1_q <= n;
    n2_q <= n1_q;
    for (int k = 0; k < 9; k++) begin
      adj_q[k] <= ADJ_W'(p_q[2*k]) - ADJ_W'(p_q[2*k+1]);
    end
    vp_q <= vp_d;
    for (int c = 0; c < 3; c++) begin
      v_q[c] <= V_W'(vp_q[c]) + V_W'(vp_q[3+c]) + V_W'(vp_q[6+c]);
    end
  end

  always_comb begin
    vec_o.valid = valid4_q;
    for (int c = 0; c < 3; c++) begin
      vec_o.v[c] = v_q[c];
    end
  end

endmodule

@@ rtl/core/cnt_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnt_scale
// magnitudes, max, shift to 16-bit mantissas, squares and their sum
// ----------------------------------------------------------------------------
module cnt_scale import cnt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cnt_vec_t vec_i,
  output cnt_scl_t scl_o
);

  logic [5:0]               valid_q;
  logic [V_W-1:0]           mag1_q [3], mag2_q [3], mag3_q [3];
  logic [2:0]               neg1_q, neg2_q, neg3_q, neg4_q, neg5_q, neg6_q;
  logic                     zero1_q, zero2_q, zero3_q, zero4_q, zero5_q, zero6_q;
  logic [V_W-1:0]           max2_q;
  logic [SH_W-1:0]          sh3_q;
  logic [MANT_W-1:0]        w4_q [3];
  logic [SQ_W-1:0]          sq5_q [3];
  logic [RHS_W-1:0]         rhs6_q [3];
  logic [SUM_W-1:0]         s6_q;
  logic [V_W-1:0]           max_d;
  logic [SH_W-1:0]          sh_d;

  always_comb begin
    max_d = mag1_q[0];
    if (mag1_q[1] > max_d) max_d = mag1_q[1];
    if (mag1_q[2] > max_d) max_d = mag1_q[2];
    sh_d = '0;
    for (int i = MANT_W; i < V_W; i++) begin
      if (max2_q[i]) sh_d = SH_W'(i - MANT_W + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[4:0], vec_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      neg1_q[c] <= vec_i.v[c][V_W-1];
      mag1_q[c] <= vec_i.v[c][V_W-1] ? V_W'(-vec_i.v[c]) : vec_i.v[c];
      mag2_q[c] <= mag1_q[c];
      mag3_q[c] <= mag2_q[c];
      w4_q[c]   <= MANT_W'(mag3_q[c] >> sh3_q);
      sq5_q[c]  <= SQ_W'(w4_q[c]) * SQ_W'(w4_q[c]);
      rhs6_q[c] <= RHS_W'(sq5_q[c]) << RHS_SHIFT;
    end
    zero1_q <= (vec_i.v[0] == '0) && (vec_i.v[1] == '0) && (vec_i.v[2] == '0);
    max2_q  <= max_d;
    sh3_q   <= sh_d;
    s6_q    <= SUM_W'(sq5_q[0]) + SUM_W'(sq5_q[1]) + SUM_W'(sq5_q[2]);
    neg2_q  <= neg1_q;  neg3_q  <= neg2_q;  neg4_q  <= neg3_q;
    neg5_q  <= neg4_q;  neg6_q  <= neg5_q;
    zero2_q <= zero1_q; zero3_q <= zero2_q; zero4_q <= zero3_q;
    zero5_q <= zero4_q; zero6_q <= zero5_q;
  end

  always_comb begin
    scl_o.valid = valid_q[5];
    scl_o.zero  = zero6_q;
    scl_o.neg   = neg6_q;
    scl_o.s     = s6_q;
    for (int c = 0; c < 3; c++) begin
      scl_o.rhs[c] = rhs6_q[c];
    end
  end

endmodule

@@ rtl/core/cnt_unit_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnt_unit_search
// one result bit per stage: largest q with (2q-1)^2 * s <= rhs, q <= 16384
// ----------------------------------------------------------------------------
module cnt_unit_search import cnt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cnt_scl_t scl_i,
  output cnt_mag_t mag_o
);

  logic                    vld_q  [SEARCH_STEPS];
  logic                    zero_q [SEARCH_STEPS];
  logic [2:0]              neg_q  [SEARCH_STEPS];
  logic [SUM_W-1:0]        s_q    [SEARCH_STEPS];
  logic [RHS_W-1:0]        rhs_q  [SEARCH_STEPS][3];
  logic signed [ACC_W-1:0] p_q    [SEARCH_STEPS][3];
  logic signed [ACC_W-1:0] qq_q   [SEARCH_STEPS][3];
  logic [Q_W-1:0]          q_q    [SEARCH_STEPS][3];

  for (genvar k = 0; k < SEARCH_STEPS; k++) begin : g_step
    localparam int B = SEARCH_STEPS - 1 - k;
    logic                    vld_in, zero_in;
    logic [2:0]              neg_in;
    logic [SUM_W-1:0]        s_in;
    logic [RHS_W-1:0]        rhs_in [3];
    logic signed [ACC_W-1:0] p_in [3], qq_in [3], s_ext;
    logic [Q_W-1:0]          q_in [3];
    logic signed [ACC_W-1:0] cand [3], p_nx [3], qq_nx [3];
    logic [Q_W-1:0]          q_nx [3];
    logic                    take [3];

    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = scl_i.valid;
        zero_in = scl_i.zero;
        neg_in  = scl_i.neg;
        s_in    = scl_i.s;
        for (int c = 0; c < 3; c++) begin
          rhs_in[c] = scl_i.rhs[c];
          p_in[c]   = $signed({{(ACC_W-SUM_W){1'b0}}, scl_i.s});
          qq_in[c]  = -$signed({{(ACC_W-SUM_W){1'b0}}, scl_i.s});
          q_in[c]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[k-1];
        zero_in = zero_q[k-1];
        neg_in  = neg_q[k-1];
        s_in    = s_q[k-1];
        for (int c = 0; c < 3; c++) begin
          rhs_in[c] = rhs_q[k-1][c];
          p_in[c]   = p_q[k-1][c];
          qq_in[c]  = qq_q[k-1][c];
          q_in[c]   = q_q[k-1][c];
        end
      end
    end

    always_comb begin
      s_ext = $signed({{(ACC_W-SUM_W){1'b0}}, s_in});
      for (int c = 0; c < 3; c++) begin
        cand[c]  = p_in[c] + (qq_in[c] <<< (B + 2)) + (s_ext <<< (2 * B + 2));
        take[c]  = (cand[c] <= $signed({{(ACC_W-RHS_W){1'b0}}, rhs_in[c]}))
                   && ((k == 0) || !q_in[c][Q_W-1]);
        p_nx[c]  = take[c] ? cand[c] : p_in[c];
        qq_nx[c] = take[c] ? qq_in[c] + (s_ext <<< (B + 1)) : qq_in[c];
        q_nx[c]  = take[c] ? (q_in[c] | (Q_W'(1) << B)) : q_in[c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[k] <= zero_in;
      neg_q[k]  <= neg_in;
      s_q[k]    <= s_in;
      for (int c = 0; c < 3; c++) begin
        rhs_q[k][c] <= rhs_in[c];
        p_q[k][c]   <= p_nx[c];
        qq_q[k][c]  <= qq_nx[c];
        q_q[k][c]   <= q_nx[c];
      end
    end
  end

  always_comb begin
    mag_o.valid = vld_q[SEARCH_STEPS-1];
    mag_o.zero  = zero_q[SEARCH_STEPS-1];
    mag_o.neg   = neg_q[SEARCH_STEPS-1];
    for (int c = 0; c < 3; c++) begin
      mag_o.q[c] = q_q[SEARCH_STEPS-1][c];
    end
  end

endmodule

@@ rtl/core/cofactor_normal_transform_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cofactor_normal_transform_top
// normal transform by adjugate transpose of a 3x3 jacobian, unit length out
//
//   channel   handshake          payload
//   request   start / busy       req_i  (cnt_req_t)
//   result    valid_o strobe     rsp_o  (cnt_rsp_t)
//
// one request per cycle; each passes the adjugate and scaling stages, the
// 15-stage bit search for the unit magnitudes and an output register
// busy stays low; the pipeline never stalls and results are one-cycle
// strobes; reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module cofactor_normal_transform_top import cnt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cnt_req_t req_i,
  output logic     valid_o,
  output cnt_rsp_t rsp_o
);

  cnt_vec_t vec;
  cnt_scl_t scl;
  cnt_mag_t mag;
  logic     valid_q;
  cnt_rsp_t rsp_q;

  assign busy = 1'b0;

  cnt_adjugate u_adj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start & ~busy),
    .req_i  (req_i),
    .vec_o  (vec)
  );

  cnt_scale u_scale (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vec_i (vec),
    .scl_o (scl)
  );

  cnt_unit_search u_search (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .scl_i (scl),
    .mag_o (mag)
  );

  function automatic logic signed [OUT_W-1:0] apply_sign(
    input logic [Q_W-1:0] q, input logic neg, input logic zero
  );
    logic signed [OUT_W-1:0] m;
    m = $signed(OUT_W'(q));
    if (zero) return '0;
    return neg ? -m : m;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= mag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.out_x       <= apply_sign(mag.q[0], mag.neg[0], mag.zero);
    rsp_q.out_y       <= apply_sign(mag.q[1], mag.neg[1], mag.zero);
    rsp_q.out_z       <= apply_sign(mag.q[2], mag.neg[2], mag.zero);
    rsp_q.zero_length <= mag.zero;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule
